// ===== hdl/skct_pkg.sv =====
// Package: item types and codes for the sorted keyframe cubic track.
package skct_pkg;

    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_EVAL = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NF   = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [15:0]        key_row;
        logic signed [31:0] coeff_const;
        logic signed [31:0] coeff_lin;
        logic signed [31:0] coeff_quad;
        logic signed [31:0] coeff_cube;
        logic [31:0]        query_pos;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic [5:0]         key_index;
    } out_item_t;

    typedef struct packed {
        logic mul_en;
    } mac_ctrl_t;

endpackage

// ===== hdl/skct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module skct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/skct_mac.sv =====
// Shared Horner step unit: registered multiply, floor shift, saturating add.
module skct_mac
    import skct_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  mac_ctrl_t          ctrl,
    input  logic signed [31:0] acc,
    input  logic [31:0]        t,
    input  logic signed [31:0] c,
    output logic signed [31:0] res,
    output logic               sat
);
    logic signed [65:0] prod_reg;
    logic signed [65:0] sh;
    logic signed [31:0] s1;
    logic               sat1;
    logic signed [32:0] sum;
    logic               sat2;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= $signed({acc[31], acc}) * $signed({1'b0, t});
        end
    end

    always_comb
    begin
        sh   = prod_reg >>> FRAC_BITS;
        sat1 = !((&sh[65:31]) || !(|sh[65:31]));
        if (sat1)
        begin
            s1 = sh[65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            s1 = sh[31:0];
        end
        sum  = {s1[31], s1} + {c[31], c};
        sat2 = sum[32] != sum[31];
        if (sat2)
        begin
            res = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            res = sum[31:0];
        end
        sat = sat1 || sat2;
    end
endmodule

// ===== hdl/sorted_keyframe_cubic_track.sv =====
// Top level: sorted keyframe table with binary search, shifting and cubic evaluation.
//  channel | ports                 | handshake
//  command | start, busy, cmd      | taken when start && !busy
//  result  | strobe, rsp           | one cycle per item, no back-pressure
// A binary search step reads a row from the row RAM and then compares it, plus a
// closing check and a dispatch state. Evaluate then loads its interval and runs the
// Horner steps, or reads out the constant term when that is the answer.
// Set shifts each later key up word by word, drains and writes the new key's words;
// delete shifts each later key down word by word and drains. Busy stays high throughout.
// Reset clears the key count; table contents need no clearing.
module sorted_keyframe_cubic_track
    import skct_pkg::*;
#(
    parameter int MAX_KEYS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  cmd,
    output logic      strobe,
    output out_item_t rsp
);
    localparam int IW  = $clog2(MAX_KEYS);
    localparam int CW  = $clog2(MAX_KEYS + 1);
    localparam int CAW = IW + 2;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_SRCH  = 13'b0000000000010,
        S_CMP   = 13'b0000000000100,
        S_DISP  = 13'b0000000001000,
        S_SHIFT = 13'b0000000010000,
        S_DRAIN = 13'b0000000100000,
        S_INS   = 13'b0000001000000,
        S_ECST  = 13'b0000010000000,
        S_EOUT  = 13'b0000100000000,
        S_ERD   = 13'b0001000000000,
        S_ELD   = 13'b0010000000000,
        S_EMUL  = 13'b0100000000000,
        S_ESHF  = 13'b1000000000000
    } state_t;

    state_t    state_reg, state_next;
    in_item_t  item_reg, item_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [IW-1:0] mid_reg, mid_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          hit_reg, hit_next;
    logic [31:0]   target_reg, target_next;
    logic [IW-1:0] e_reg, e_next;
    logic [CAW-1:0] p_reg, p_next;
    logic [1:0]    k_reg, k_next;
    logic signed [31:0] acc_reg, acc_next;
    logic [31:0]   t_reg, t_next;
    logic          sat_reg, sat_next;
    logic          pend_reg, pend_next;
    logic [CAW-1:0] pend_caddr_reg, pend_caddr_next;
    logic [IW-1:0] pend_raddr_reg, pend_raddr_next;
    logic          strobe_reg, strobe_next;
    out_item_t     rsp_reg, rsp_next;

    logic          row_we;
    logic [IW-1:0] row_waddr, row_raddr;
    logic [15:0]   row_wdata, row_rdata;
    logic          cf_we;
    logic [CAW-1:0] cf_waddr, cf_raddr;
    logic [31:0]   cf_wdata, cf_rdata;

    mac_ctrl_t          mac_ctrl;
    logic signed [31:0] mac_res;
    logic               mac_sat;

    logic [CW:0]   mid_sum;
    logic [CW-1:0] idx_p1;
    logic [IW+5:0] e_ix, idx_ix;
    logic [47:0]   row_sh;
    logic [47:0]   t_full;
    logic [31:0]   row_ext;

    skct_ram #(.WIDTH(16), .DEPTH(MAX_KEYS)) u_rows (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata)
    );

    skct_ram #(.WIDTH(32), .DEPTH(MAX_KEYS * 4)) u_coeffs (
        .clk(clk), .we(cf_we), .waddr(cf_waddr), .wdata(cf_wdata),
        .raddr(cf_raddr), .rdata(cf_rdata)
    );

    skct_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk(clk), .ctrl(mac_ctrl), .acc(acc_reg), .t(t_reg),
        .c($signed(cf_rdata)), .res(mac_res), .sat(mac_sat)
    );

    always_comb
    begin
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        idx_p1  = idx_reg + 1'b1;
        e_ix    = {6'b0, e_reg};
        idx_ix  = {6'b0, idx_reg[IW-1:0]};
        row_ext = {16'b0, row_rdata};
        row_sh  = {32'b0, row_rdata} << FRAC_BITS;
        t_full  = {16'b0, item_reg.query_pos} - row_sh;
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        hit_next        = hit_reg;
        target_next     = target_reg;
        e_next          = e_reg;
        p_next          = p_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        t_next          = t_reg;
        sat_next        = sat_reg;
        pend_next       = 1'b0;
        pend_caddr_next = pend_caddr_reg;
        pend_raddr_next = pend_raddr_reg;
        strobe_next     = 1'b0;
        rsp_next        = rsp_reg;
        row_raddr       = mid_sum[IW:1];
        cf_raddr        = p_reg;
        mac_ctrl.mul_en = 1'b0;

        // shift copies are written in the cycle after their read
        row_we    = pend_reg;
        row_waddr = pend_raddr_reg;
        row_wdata = row_rdata;
        cf_we     = pend_reg;
        cf_waddr  = pend_caddr_reg;
        cf_wdata  = cf_rdata;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next   = cmd;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    hit_next    = 1'b0;
                    sat_next    = 1'b0;
                    rsp_next    = '0;
                    if (cmd.opcode == OP_SET || cmd.opcode == OP_DEL)
                    begin
                        target_next = {16'b0, cmd.key_row};
                        state_next  = S_SRCH;
                    end
                    else if (cmd.opcode == OP_EVAL && count_reg != '0)
                    begin
                        target_next = cmd.query_pos >> FRAC_BITS;
                        state_next  = S_SRCH;
                    end
                    else
                    begin
                        strobe_next = 1'b1;
                    end
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_sum[IW:1];
                    state_next = S_CMP;
                end
                else
                begin
                    idx_next   = lo_reg;
                    state_next = S_DISP;
                end
            end
            S_CMP:
            begin
                priority if (row_ext < target_reg)
                begin
                    lo_next    = CW'(mid_reg) + 1'b1;
                    state_next = S_SRCH;
                end
                else if (row_ext > target_reg)
                begin
                    hi_next    = CW'(mid_reg);
                    state_next = S_SRCH;
                end
                else
                begin
                    hit_next   = 1'b1;
                    idx_next   = CW'(mid_reg);
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                k_next = 2'd0;
                if (item_reg.opcode == OP_SET)
                begin
                    if (!hit_reg && count_reg >= CW'(MAX_KEYS))
                    begin
                        rsp_next.status = ST_FULL;
                        strobe_next     = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (!hit_reg && idx_reg != count_reg)
                    begin
                        // start at the last word of the last live key
                        p_next     = {count_reg[IW-1:0] - 1'b1, 2'b11};
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_INS;
                    end
                end
                else if (item_reg.opcode == OP_DEL)
                begin
                    if (!hit_reg)
                    begin
                        rsp_next.status = ST_NF;
                        strobe_next     = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else if (idx_p1 != count_reg)
                    begin
                        p_next     = {idx_p1[IW-1:0], 2'b00};
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        count_next         = count_reg - 1'b1;
                        rsp_next.key_index = idx_ix[5:0];
                        strobe_next        = 1'b1;
                        state_next         = S_IDLE;
                    end
                end
                else
                begin
                    if (!hit_reg && idx_reg == '0)
                    begin
                        e_next     = '0;
                        state_next = S_ECST;
                    end
                    else
                    begin
                        if (hit_reg)
                        begin
                            e_next = idx_reg[IW-1:0];
                        end
                        else
                        begin
                            e_next = idx_reg[IW-1:0] - 1'b1;
                        end
                        if ((hit_reg ? idx_p1 : idx_reg) >= count_reg)
                        begin
                            state_next = S_ECST;
                        end
                        else
                        begin
                            state_next = S_ERD;
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                row_raddr = p_reg[CAW-1:2];
                cf_raddr  = p_reg;
                pend_next = 1'b1;
                if (item_reg.opcode == OP_SET)
                begin
                    pend_caddr_next = p_reg + CAW'(4);
                    pend_raddr_next = p_reg[CAW-1:2] + 1'b1;
                    if (p_reg == {idx_reg[IW-1:0], 2'b00})
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        p_next = p_reg - 1'b1;
                    end
                end
                else
                begin
                    pend_caddr_next = p_reg - CAW'(4);
                    pend_raddr_next = p_reg[CAW-1:2] - 1'b1;
                    if (p_reg == {count_reg[IW-1:0] - 1'b1, 2'b11})
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        p_next = p_reg + 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                if (item_reg.opcode == OP_DEL)
                begin
                    count_next         = count_reg - 1'b1;
                    rsp_next.key_index = idx_ix[5:0];
                    strobe_next        = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                cf_we     = 1'b1;
                cf_waddr  = {idx_reg[IW-1:0], k_reg};
                unique case (k_reg)
                    2'd0: cf_wdata = item_reg.coeff_const;
                    2'd1: cf_wdata = item_reg.coeff_lin;
                    2'd2: cf_wdata = item_reg.coeff_quad;
                    default: cf_wdata = item_reg.coeff_cube;
                endcase
                row_we    = (k_reg == 2'd0);
                row_waddr = idx_reg[IW-1:0];
                row_wdata = item_reg.key_row;
                k_next    = k_reg + 1'b1;
                if (k_reg == 2'd3)
                begin
                    if (!hit_reg)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    rsp_next.key_index = idx_ix[5:0];
                    strobe_next        = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_ECST:
            begin
                cf_raddr   = {e_reg, 2'b00};
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                rsp_next.value     = $signed(cf_rdata);
                rsp_next.key_index = e_ix[5:0];
                strobe_next        = 1'b1;
                state_next         = S_IDLE;
            end
            S_ERD:
            begin
                row_raddr  = e_reg;
                cf_raddr   = {e_reg, 2'b11};
                state_next = S_ELD;
            end
            S_ELD:
            begin
                acc_next   = $signed(cf_rdata);
                t_next     = t_full[31:0];
                k_next     = 2'd2;
                state_next = S_EMUL;
            end
            S_EMUL:
            begin
                mac_ctrl.mul_en = 1'b1;
                cf_raddr        = {e_reg, k_reg};
                state_next      = S_ESHF;
            end
            S_ESHF:
            begin
                acc_next = mac_res;
                sat_next = sat_reg || mac_sat;
                if (k_reg == 2'd0)
                begin
                    rsp_next.value     = mac_res;
                    rsp_next.status    = (sat_reg || mac_sat) ? ST_SAT : ST_OK;
                    rsp_next.key_index = e_ix[5:0];
                    strobe_next        = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = S_EMUL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        hit_reg        <= hit_next;
        target_reg     <= target_next;
        e_reg          <= e_next;
        p_reg          <= p_next;
        k_reg          <= k_next;
        acc_reg        <= acc_next;
        t_reg          <= t_next;
        sat_reg        <= sat_next;
        pend_caddr_reg <= pend_caddr_next;
        pend_raddr_reg <= pend_raddr_next;
        rsp_reg        <= rsp_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign rsp    = rsp_reg;

`ifndef SYNTH
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> state_reg == S_IDLE)
        else $error("result strobe while sequencer busy");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_KEYS))
        else $error("key count above table size");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.opcode == OP_SET || cmd.opcode == OP_DEL)) |=> busy)
        else $error("set/delete item did not start the sequencer");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && rsp.status == ST_FULL) |-> (rsp.value == 0 && rsp.key_index == 0))
        else $error("full report carries data");
`endif
endmodule
